### sv/erd_pkg.sv
// erd_pkg: shared types and constants for the escaped record deframer.
// No dependencies; imported by the collector and the top level.
package erd_pkg;

    localparam logic [7:0]  DELIM_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  ESC_XOR    = 8'h20;
    localparam logic [15:0] IRQ_ID     = 16'hFFFF;
    localparam logic [15:0] IDLE_ID    = 16'h0000;
    // Position of the last data byte of a record (seven bytes, 0..6).
    localparam logic [2:0]  LAST_POS   = 3'd6;

    typedef struct packed {
        logic [15:0]        trans_id;
        logic [7:0]         operation;
        logic [15:0]        address;
        logic signed [15:0] value;
        logic               is_irq;
    } rec_t;

endpackage

### sv/erd_stream_if.sv
// Valid/ready channel interfaces for the deframer: raw byte in, record out.
// No dependencies.
interface erd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface erd_rec_if;
    logic               valid;
    logic               ready;
    logic [15:0]        trans_id;
    logic [7:0]         operation;
    logic [15:0]        address;
    logic signed [15:0] value;
    logic               is_irq;

    modport source (output valid, output trans_id, output operation, output address,
                    output value, output is_irq, input ready);
    modport sink   (input valid, input trans_id, input operation, input address,
                    input value, input is_irq, output ready);
endinterface

### sv/erd_collect.sv
// erd_collect: escape removal and record assembly, one byte per step.
// Depends on erd_pkg.
module erd_collect (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   rx_byte,
    output logic         rec_valid,
    output erd_pkg::rec_t rec
);
    import erd_pkg::*;

    logic        esc_reg,     esc_next;
    logic [2:0]  count_reg,   count_next;
    logic [47:0] partial_reg, partial_next;
    logic [7:0]  data_byte;
    logic [55:0] full_rec;
    logic [5:0]  bit_pos;

    always_comb
    begin
        data_byte    = esc_reg ? (rx_byte ^ ESC_XOR) : rx_byte;
        full_rec     = {data_byte, partial_reg};
        bit_pos      = {count_reg, 3'b000};
        esc_next     = esc_reg;
        count_next   = count_reg;
        partial_next = partial_reg;
        rec_valid    = 1'b0;

        rec.trans_id  = full_rec[15:0];
        rec.operation = full_rec[23:16];
        rec.address   = full_rec[39:24];
        rec.value     = full_rec[55:40];
        rec.is_irq    = (full_rec[15:0] == IRQ_ID);

        if (step)
        begin
            if (rx_byte == DELIM_BYTE)
            begin
                esc_next     = 1'b0;
                count_next   = '0;
                partial_next = '0;
            end
            else if (rx_byte == ESC_BYTE)
            begin
                esc_next = 1'b1;
            end
            else if (count_reg < LAST_POS)
            begin
                esc_next                  = 1'b0;
                partial_next[bit_pos +: 8] = data_byte;
                count_next                = count_reg + 3'd1;
            end
            else
            begin
                // Seventh data byte: record done, drop it if the id is idle.
                esc_next     = 1'b0;
                count_next   = '0;
                partial_next = '0;
                rec_valid    = (full_rec[15:0] != IDLE_ID);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg     <= 1'b0;
            count_reg   <= '0;
            partial_reg <= '0;
        end
        else
        begin
            esc_reg     <= esc_next;
            count_reg   <= count_next;
            partial_reg <= partial_next;
        end
    end

endmodule

### sv/escaped_record_deframer_core.sv
// escaped_record_deframer_core: top level of the byte-stuffed record deframer.
// Depends on erd_pkg, erd_stream_if (erd_byte_if, erd_rec_if) and erd_collect.
//
// Usage notes:
//   rx  : one raw serial byte per beat. 0x7E is a frame delimiter, 0x7D
//         escapes the next byte (stored XOR 0x20). Other bytes are data.
//   rec : one beat per completed 7-byte record (id, operation, address,
//         signed value, irq flag). Records with id zero are dropped;
//         id 0xFFFF comes out with is_irq set.
//   Path: a byte taken from rx sits in the input register until it is
//   decoded; a record it completes is registered, then valid on rec.
//   Throughput: one byte per cycle while rec drains. The input register, the
//   single-step collector and the result register form a two-stage path.
//   Stall: the collector only steps when the result register is empty or
//   being drained. While a record waits on rec with ready low, the byte in
//   the input register holds, whether or not it would complete a record,
//   and the collector state is frozen. An empty input register still takes
//   one more byte, then rx.ready stays low until rec drains.
//   No beat is lost or repeated.
//   Reset: rst_n (async, active low) empties both registers and clears the
//   escape flag, byte count and partial record.
module escaped_record_deframer_core (
    input  logic           clk,
    input  logic           rst_n,
    erd_byte_if.sink       rx,
    erd_rec_if.source      rec
);
    import erd_pkg::*;

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg,  in_byte_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    rec_t       out_rec_reg,   out_rec_next;

    logic       res_free;
    logic       fire;
    logic       col_valid;
    rec_t       col_rec;

    // Result slot can take a new record when empty or being drained.
    assign res_free = !out_valid_reg || rec.ready;
    assign fire     = in_valid_reg && res_free;
    assign rx.ready = !in_valid_reg || fire;

    erd_collect u_collect (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .rx_byte   (in_byte_reg),
        .rec_valid (col_valid),
        .rec       (col_rec)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (rx.valid && rx.ready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = rx.rx_byte;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_rec_next   = out_rec_reg;
        if (fire && col_valid)
        begin
            out_valid_next = 1'b1;
            out_rec_next   = col_rec;
        end
        else if (rec.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        out_rec_reg <= out_rec_next;
    end

    assign rec.valid     = out_valid_reg;
    assign rec.trans_id  = out_rec_reg.trans_id;
    assign rec.operation = out_rec_reg.operation;
    assign rec.address   = out_rec_reg.address;
    assign rec.value     = out_rec_reg.value;
    assign rec.is_irq    = out_rec_reg.is_irq;

    // A record shows up only right after a decode step.
    a_rec_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire))
        else $error("record appeared without a decode step");

    // Idle-id records never reach the output.
    a_no_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
        rec.valid |-> (rec.trans_id != IDLE_ID))
        else $error("record with idle id emitted");

    // Irq flag tracks the all-ones id.
    a_irq_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rec.valid |-> (rec.is_irq == (rec.trans_id == IRQ_ID)))
        else $error("irq flag does not match id");

    // A held input byte is not dropped while the result slot is blocked.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending input byte lost");

endmodule
